FILE: rtl/pwk_pkg.sv
// Shared types and constants for the four-level page table walker.
// Used by pwk_front, pwk_fifo, pwk_back and page_table_walker_core; no dependencies.
package pwk_pkg;

	// Number of physical address bits held in a table entry (32..52).
	localparam int unsigned FRAME_BITS = 52;

	localparam logic [63:0] FRAME_MASK =
		((64'd1 << FRAME_BITS) - 64'd1) & ~64'h0000_0000_0000_0FFF;
	localparam logic [63:0] HUGE_OFFSET_MASK  = 64'h0000_0000_001F_FFFF;
	localparam logic [63:0] SMALL_OFFSET_MASK = 64'h0000_0000_0000_0FFF;
	localparam logic [63:0] KERN_BASE_RESET   = 64'hFFFF_8800_0000_0000;

	localparam int unsigned PRESENT_BIT = 0;
	localparam int unsigned HUGE_BIT    = 7;

	// Depth of the queue between the front and the back.
	localparam int unsigned QUEUE_DEPTH = 2;

	typedef enum logic {
		OP_START = 1'b0,
		OP_DATA  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		KIND_REQUEST = 2'd0,
		KIND_DONE    = 2'd1,
		KIND_IGNORED = 2'd2
	} kind_t;

	// Walk level: number of the entry that is read next, or idle.
	typedef enum logic [2:0] {
		LVL_IDLE = 3'd0,
		LVL_1    = 3'd1,
		LVL_2    = 3'd2,
		LVL_3    = 3'd3,
		LVL_4    = 3'd4
	} level_t;

	// One classified request handed from the front to the back.
	typedef struct packed {
		kind_t       kind;
		logic        use_kern;
		logic [63:0] operand;
		logic [11:0] offset;
	} walk_op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

FILE: rtl/pwk_front.sv
// Front end of the page table walker: accepts requests, tracks the walk level
// and classifies each request into a walk_op_t. Depends on pwk_pkg.
module pwk_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               operation,
	input  logic [63:0]        virtual_address,
	input  logic [63:0]        table_base,
	input  logic [63:0]        read_data,
	output logic               push_valid,
	output pwk_pkg::walk_op_t  push_op,
	input  logic               queue_full
);

	pwk_pkg::level_t level_q;
	pwk_pkg::level_t level_next;
	logic [63:0]     saved_va_q;
	logic [63:0]     va_src;
	logic [8:0]      index;
	logic [63:0]     frame;
	logic            is_huge;
	logic            accept;

	assign in_ready   = !queue_full;
	assign accept     = in_valid && in_ready;
	assign push_valid = accept;

	assign va_src  = (pwk_pkg::op_t'(operation) == pwk_pkg::OP_START) ?
		virtual_address : saved_va_q;
	assign frame   = read_data & pwk_pkg::FRAME_MASK;
	assign is_huge = read_data[pwk_pkg::PRESENT_BIT] && read_data[pwk_pkg::HUGE_BIT];

	// Index of the entry read next, taken from the virtual address.
	always_comb begin
		index = va_src[47:39];
		if (pwk_pkg::op_t'(operation) == pwk_pkg::OP_DATA) begin
			unique case (level_q)
				pwk_pkg::LVL_1: index = va_src[38:30];
				pwk_pkg::LVL_2: index = va_src[29:21];
				pwk_pkg::LVL_3: index = va_src[20:12];
				default:        index = va_src[47:39];
			endcase
		end
	end

	// Next level.
	always_comb begin
		level_next = level_q;
		if (pwk_pkg::op_t'(operation) == pwk_pkg::OP_START) begin
			level_next = pwk_pkg::LVL_1;
		end else begin
			unique case (level_q)
				pwk_pkg::LVL_1: level_next = pwk_pkg::LVL_2;
				pwk_pkg::LVL_2: level_next = pwk_pkg::LVL_3;
				pwk_pkg::LVL_3: level_next = is_huge ? pwk_pkg::LVL_IDLE : pwk_pkg::LVL_4;
				default:        level_next = pwk_pkg::LVL_IDLE;
			endcase
		end
	end

	// Classified request.
	always_comb begin
		push_op.kind     = pwk_pkg::KIND_REQUEST;
		push_op.use_kern = 1'b1;
		push_op.operand  = frame | {52'd0, index, 3'd0};
		push_op.offset   = 12'd0;
		if (pwk_pkg::op_t'(operation) == pwk_pkg::OP_START) begin
			push_op.use_kern = 1'b0;
			push_op.operand  = table_base;
			push_op.offset   = {index, 3'd0};
		end else begin
			unique case (level_q)
				pwk_pkg::LVL_1, pwk_pkg::LVL_2: begin
				end
				pwk_pkg::LVL_3: begin
					if (is_huge) begin
						push_op.kind     = pwk_pkg::KIND_DONE;
						push_op.use_kern = 1'b0;
						push_op.operand  = (frame & ~pwk_pkg::HUGE_OFFSET_MASK) |
							(va_src & pwk_pkg::HUGE_OFFSET_MASK);
					end
				end
				pwk_pkg::LVL_4: begin
					push_op.kind     = pwk_pkg::KIND_DONE;
					push_op.use_kern = 1'b0;
					push_op.operand  = frame | (va_src & pwk_pkg::SMALL_OFFSET_MASK);
				end
				default: begin
					push_op.kind     = pwk_pkg::KIND_IGNORED;
					push_op.use_kern = 1'b0;
					push_op.operand  = 64'd0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q    <= pwk_pkg::LVL_IDLE;
			saved_va_q <= 64'd0;
		end else if (accept) begin
			level_q <= level_next;
			if (pwk_pkg::op_t'(operation) == pwk_pkg::OP_START) begin
				saved_va_q <= virtual_address;
			end
		end
	end

endmodule

FILE: rtl/pwk_fifo.sv
// Short queue of classified walk requests between the front and the back.
// Depends on pwk_pkg for walk_op_t, queue_status_t and QUEUE_DEPTH.
module pwk_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push_valid,
	input  pwk_pkg::walk_op_t      push_op,
	output logic                   pop_valid,
	input  logic                   pop_ready,
	output pwk_pkg::walk_op_t      pop_op,
	output pwk_pkg::queue_status_t status
);

	localparam int unsigned PTR_W = (pwk_pkg::QUEUE_DEPTH > 1) ?
		$clog2(pwk_pkg::QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(pwk_pkg::QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(pwk_pkg::QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(pwk_pkg::QUEUE_DEPTH);

	pwk_pkg::walk_op_t entries_q [pwk_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign status.full  = (count_q == FULL_CNT);
	assign status.empty = (count_q == '0);
	assign pop_valid    = !status.empty;
	assign pop_op       = entries_q[rd_ptr_q];
	assign do_push      = push_valid && !status.full;
	assign do_pop       = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

FILE: rtl/pwk_back.sv
// Back end of the page table walker: holds kern_base, forms the final address
// sum and drives the registered result channel. Depends on pwk_pkg.
module pwk_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [63:0]       cfg_wdata,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  pwk_pkg::walk_op_t pop_op,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        kind,
	output logic [63:0]       request_address,
	output logic [63:0]       physical_address
);

	logic [63:0] kern_base_q;
	logic [63:0] addend;
	logic [63:0] sum;
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [63:0] request_address_q;
	logic [63:0] physical_address_q;

	assign pop_ready = !out_valid_q || out_ready;

	assign addend = pop_op.use_kern ? kern_base_q : {52'd0, pop_op.offset};
	assign sum    = pop_op.operand + addend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kern_base_q <= pwk_pkg::KERN_BASE_RESET;
		end else if (cfg_we) begin
			kern_base_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop_ready) begin
			out_valid_q <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			kind_q             <= pop_op.kind;
			request_address_q  <= (pop_op.kind == pwk_pkg::KIND_REQUEST) ? sum : 64'd0;
			physical_address_q <= (pop_op.kind == pwk_pkg::KIND_DONE) ? pop_op.operand : 64'd0;
		end
	end

	assign out_valid        = out_valid_q;
	assign kind             = kind_q;
	assign request_address  = request_address_q;
	assign physical_address = physical_address_q;

endmodule

FILE: rtl/page_table_walker_core.sv
// Top level of the four-level page table walker: front end, request queue and
// back end. Depends on pwk_pkg, pwk_front, pwk_fifo and pwk_back.
//
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    operation, virtual_address, table_base, read_data
// out       output     out_valid / out_ready  kind, request_address, physical_address
// cfg       input      cfg_we                 cfg_wdata (kern_base)
//
// A request's result reaches the output register by way of the queue: the queue
// takes the classified request at acceptance and the address adder feeds the
// output register when the entry is popped. A request can be accepted every cycle;
// in_ready drops only when the two-entry queue is full behind a stalled output.
// Reset is asynchronous and active low; it returns the walker to idle and
// restores kern_base to the kernel direct-map base.
module page_table_walker_core (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: kern_base.
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata,
	// Input requests: walk starts and returned table entries.
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [63:0] virtual_address,
	input  logic [63:0] table_base,
	input  logic [63:0] read_data,
	// Results: entry read requests, translations and ignored data.
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [63:0] request_address,
	output logic [63:0] physical_address
);

	pwk_pkg::walk_op_t      push_op;
	pwk_pkg::walk_op_t      pop_op;
	pwk_pkg::queue_status_t queue_status;
	logic                   push_valid;
	logic                   pop_valid;
	logic                   pop_ready;

	// The front end owns the walk level and the saved virtual address, so the
	// classification of every request is settled at acceptance. It also
	// prepares the operands so that only one 64-bit add remains for the back.
	pwk_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.virtual_address (virtual_address),
		.table_base      (table_base),
		.read_data       (read_data),
		.push_valid      (push_valid),
		.push_op         (push_op),
		.queue_full      (queue_status.full)
	);

	pwk_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_op    (push_op),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_op     (pop_op),
		.status     (queue_status)
	);

	// The back end adds either kern_base (table frame) or the scaled index
	// (start of a walk) and registers the result for the output channel.
	pwk_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.pop_valid        (pop_valid),
		.pop_ready        (pop_ready),
		.pop_op           (pop_op),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.kind             (kind),
		.request_address  (request_address),
		.physical_address (physical_address)
	);

	// The queue is never reported full and empty at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(queue_status.full && queue_status.empty))
		else $error("queue reports full and empty together");

	// A request accepted into an empty queue with a free output shows up next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && queue_status.empty && (!out_valid || out_ready))
		|=> pop_valid)
		else $error("accepted request did not reach the queue");

	// Address fields not belonging to the result kind are zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == pwk_pkg::KIND_REQUEST) |-> (physical_address == 64'd0))
		else $error("read request carries a physical address");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == pwk_pkg::KIND_IGNORED) |->
		(request_address == 64'd0 && physical_address == 64'd0))
		else $error("ignored data carries an address");

	// Only the three defined result kinds leave the block.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind == pwk_pkg::KIND_REQUEST || kind == pwk_pkg::KIND_DONE ||
		kind == pwk_pkg::KIND_IGNORED))
		else $error("undefined result kind");

endmodule
